// ===== src/stds_pkg.sv =====
// ----------------------------------------------------------------------------
// stds_pkg: shared types and constants of the sighting table
// item layouts, outcome codes, register indexes and score thresholds
// ----------------------------------------------------------------------------
package stds_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegRssiFloor     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDecayInterval = 3'd1;
  localparam logic [CfgIdxW-1:0] RegScoreCooldown = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDeviceTtl     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFollowerHits  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFollowerSpan  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFollowerPts   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegScoreLimit    = 3'd7;

  localparam logic [2:0] OutReportable = 3'd0;
  localparam logic [2:0] OutTracked    = 3'd1;
  localparam logic [2:0] OutWeak       = 3'd2;
  localparam logic [2:0] OutMuted      = 3'd3;
  localparam logic [2:0] OutTickDone   = 3'd4;

  localparam logic [15:0] AlertAt   = 16'd6;
  localparam logic [15:0] CautionAt = 16'd3;

  typedef struct packed {
    logic               command;
    logic [47:0]        now_time;
    logic [47:0]        mac_address;
    logic signed [7:0]  rssi;
    logic               from_ble;
    logic               cls_match;
    logic [3:0]         class_code;
    logic [7:0]         class_points;
    logic               muted;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         outcome;
    logic [5:0]         slot_index;
    logic [3:0]         device_class;
    logic               is_follower;
    logic [15:0]        hit_count;
    logic signed [7:0]  best_rssi;
    logic [15:0]        score;
    logic [1:0]         level;
    logic [6:0]         classified_count;
    logic [31:0]        sighting_count;
  } out_item_t;

  // one slot record as held in the table memory
  typedef struct packed {
    logic [47:0]        address;
    logic [47:0]        first_seen;
    logic [47:0]        last_seen;
    logic [15:0]        hits;
    logic signed [7:0]  rssi;
    logic               follower;
    logic [3:0]         class_code;
    logic [7:0]         points;
    logic               scored_once;
    logic [47:0]        last_scored;
  } slot_rec_t;

  typedef struct packed {
    logic signed [7:0]  rssi_floor;
    logic [31:0]        decay_interval;
    logic [31:0]        score_cooldown;
    logic [31:0]        device_ttl;
    logic [15:0]        follower_min_hits;
    logic [31:0]        follower_min_span;
    logic [7:0]         follower_points;
    logic [15:0]        score_limit;
  } cfg_t;

endpackage

// ===== src/stds_slot_ram.sv =====
// ----------------------------------------------------------------------------
// stds_slot_ram: slot record memory
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module stds_slot_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  stds_pkg::slot_rec_t wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output stds_pkg::slot_rec_t rdata_o
);

  stds_pkg::slot_rec_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/stds_decay.sv =====
// ----------------------------------------------------------------------------
// stds_decay: lazy score decay unit
// restoring division of elapsed time by the interval, one quotient bit a cycle
// ----------------------------------------------------------------------------
module stds_decay (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] elapsed_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [47:0] quot_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [47:0] num_q, num_d;
  logic [47:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [32:0] trial;

  assign trial  = {rem_q[31:0], num_q[47]};
  assign quot_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd48;
      num_d  = elapsed_i;
      quo_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[46:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end else if (cnt_q == 6'd0) begin
      done_o = 1'b0;
    end
    if (busy_q && cnt_q == 6'd1) begin
      done_o = 1'b1;
    end
  end

  // done_o comes with the last step; quotient is valid the cycle after
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

endmodule

// ===== src/sighting_table_with_decaying_score.sv =====
// ----------------------------------------------------------------------------
// sighting_table_with_decaying_score: device sighting table with threat score
// tracks radio devices by address and keeps a lazily decaying score
// ----------------------------------------------------------------------------
// usage:
//   in channel  (in_valid_i / in_stall_o / in_item_i) carries sightings and
//   ticks; out channel (out_valid_o / out_stall_i / out_item_o) returns one
//   result item per input item, in order
//   config writes (cfg_we_i, cfg_idx_i, cfg_data_i) belong to idle periods,
//   with no item in flight
// sequence and throughput:
//   a rejected sighting has its result staged straight from the idle state;
//   an accepted sighting or a tick first decays the score (48-step serial
//   divider, run when the score is nonzero, time has not gone back and the
//   interval is nonzero; a zero interval clears the score), then scans every
//   slot through the single read port, a read state and a scan state a slot;
//   a sighting ends with a read-modify-write (StApply, StRdSlot, StWrite), a
//   tick with StEmit; one item is in work at a time; the next is taken once
//   the result has left the staging register
// reset:
//   all slots become free, score, decay time and counters clear, registers
//   take their defaults; no clearing pass is needed (valid bits in flops)
// stall:
//   a held result blocks the next result but the next item is still taken
//   and worked up to its result, which then waits in the staging register
// ----------------------------------------------------------------------------
module sighting_table_with_decaying_score #(
  parameter int unsigned TABLE_SLOTS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  stds_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output stds_pkg::out_item_t              out_item_o,
  input  logic                             cfg_we_i,
  input  logic [stds_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [stds_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [3:0] {
    StIdle, StScanRd, StScan, StDecay, StDecayWait, StApply, StRdSlot, StWrite,
    StTick, StEmit
  } state_e;

  // ---------------- configuration registers ----------------
  stds_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rssi_floor        <= -8'sd90;
      cfg_q.decay_interval    <= 32'd10000000;
      cfg_q.score_cooldown    <= 32'd30000000;
      cfg_q.device_ttl        <= 32'd300000000;
      cfg_q.follower_min_hits <= 16'd5;
      cfg_q.follower_min_span <= 32'd120000000;
      cfg_q.follower_points   <= 8'd2;
      cfg_q.score_limit       <= 16'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        stds_pkg::RegRssiFloor:     cfg_q.rssi_floor        <= cfg_data_i[7:0];
        stds_pkg::RegDecayInterval: cfg_q.decay_interval    <= cfg_data_i;
        stds_pkg::RegScoreCooldown: cfg_q.score_cooldown    <= cfg_data_i;
        stds_pkg::RegDeviceTtl:     cfg_q.device_ttl        <= cfg_data_i;
        stds_pkg::RegFollowerHits:  cfg_q.follower_min_hits <= cfg_data_i[15:0];
        stds_pkg::RegFollowerSpan:  cfg_q.follower_min_span <= cfg_data_i;
        stds_pkg::RegFollowerPts:   cfg_q.follower_points   <= cfg_data_i[7:0];
        stds_pkg::RegScoreLimit:    cfg_q.score_limit       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- state ----------------
  state_e                 state_q;
  stds_pkg::in_item_t     item_q;
  logic [TABLE_SLOTS-1:0] valid_q;       // slot in use
  logic [TABLE_SLOTS-1:0] cls_q;         // slot classified
  logic [15:0]            score_q;
  logic [47:0]            last_decay_q;
  logic [31:0]            total_q;
  logic [SlotW-1:0]       idx_q;         // scan pointer
  logic [SlotW-1:0]       sel_q;         // chosen slot
  logic                   hit_q;         // address match found
  logic                   vic_unc_q;     // unclassified victim found
  logic [SlotW-1:0]       vic_q;
  logic [47:0]            vic_seen_q;
  logic [SlotW-1:0]       old_q;         // oldest slot in use
  logic [47:0]            old_seen_q;
  logic                   free_q;        // free slot found
  logic [SlotW-1:0]       free_idx_q;
  stds_pkg::out_item_t    res_q;         // staged result
  logic                   res_v_q;
  stds_pkg::out_item_t    out_q;
  logic                   out_v_q;

  // ---------------- slot memory ----------------
  logic                   ram_we;
  logic [SlotW-1:0]       ram_waddr;
  stds_pkg::slot_rec_t    ram_wdata;
  logic [SlotW-1:0]       ram_raddr;
  stds_pkg::slot_rec_t    ram_rdata;

  stds_slot_ram #(.Depth(TABLE_SLOTS), .AddrW(SlotW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------- decay divider ----------------
  logic        dv_start, dv_done;
  logic [47:0] dv_quot;

  stds_decay u_decay (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (dv_start),
    .elapsed_i (item_q.now_time - last_decay_q),
    .divisor_i (cfg_q.decay_interval),
    .done_o    (dv_done),
    .quot_o    (dv_quot)
  );

  // ---------------- handshakes ----------------
  logic in_acc, out_free;
  assign in_stall_o  = (state_q != StIdle) || res_v_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_v_q || !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // ---------------- combinational helpers ----------------
  logic             weak_in, is_last;
  logic [47:0]      step_time;
  logic [47:0]      steps;
  logic [CntW-1:0]  cls_cnt;
  logic [TABLE_SLOTS-1:0] cls_next;
  logic [TABLE_SLOTS-1:0] valid_next;
  logic [47:0]      age;

  assign weak_in = (in_item_i.rssi != 8'sd0) && (in_item_i.rssi < cfg_q.rssi_floor);
  assign is_last = (idx_q == SlotW'(TABLE_SLOTS - 1));
  assign steps   = (dv_quot > {32'd0, score_q}) ? {32'd0, score_q} : dv_quot;
  assign age     = item_q.now_time - ram_rdata.last_seen;

  // bounded: steps <= 65535, product fits 48 bits
  logic [47:0] decay_adv;
  assign decay_adv = steps[15:0] * cfg_q.decay_interval;
  assign step_time = last_decay_q + decay_adv;

  always_comb begin
    cls_cnt = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      cls_cnt = cls_cnt + CntW'(valid_next[i] & cls_next[i]);
    end
  end

  function automatic logic [1:0] level_of(input logic [15:0] s);
    if (s >= stds_pkg::AlertAt) begin
      return 2'd2;
    end else if (s >= stds_pkg::CautionAt) begin
      return 2'd1;
    end
    return 2'd0;
  endfunction

  // ---------------- read-modify-write of the chosen slot ----------------
  stds_pkg::slot_rec_t rec_new;
  logic                now_cls;
  logic [15:0]         score_new;
  logic [16:0]         score_sum;

  always_comb begin
    stds_pkg::slot_rec_t r;
    logic                c;
    logic                span_ok;
    logic                cool_ok;
    r = ram_rdata;
    c = cls_q[sel_q] && hit_q;
    if (!hit_q) begin
      r = '0;
      r.address    = item_q.mac_address;
      r.first_seen = item_q.now_time;
    end
    if (r.hits != 16'hffff) begin
      r.hits = r.hits + 16'd1;
    end
    r.last_seen = item_q.now_time;
    if (item_q.rssi != 8'sd0 && (r.rssi == 8'sd0 || item_q.rssi > r.rssi)) begin
      r.rssi = item_q.rssi;
    end
    span_ok = (item_q.now_time >= r.first_seen) &&
              ((item_q.now_time - r.first_seen) >= {16'd0, cfg_q.follower_min_span});
    if (item_q.cls_match) begin
      r.class_code = item_q.class_code;
      r.points     = item_q.class_points;
      r.follower   = 1'b0;
      c            = 1'b1;
    end else if (!c && item_q.from_ble && r.hits >= cfg_q.follower_min_hits && span_ok) begin
      r.class_code = '0;
      r.points     = cfg_q.follower_points;
      r.follower   = 1'b1;
      c            = 1'b1;
    end
    score_new = score_q;
    score_sum = {1'b0, score_q} + {9'd0, r.points};
    cool_ok   = !r.scored_once ||
                ((item_q.now_time >= r.last_scored) &&
                 ((item_q.now_time - r.last_scored) >= {16'd0, cfg_q.score_cooldown}));
    if (c && r.points != 8'd0 && cool_ok) begin
      r.scored_once = 1'b1;
      r.last_scored = item_q.now_time;
      score_new = (score_sum > {1'b0, cfg_q.score_limit}) ? cfg_q.score_limit
                                                          : score_sum[15:0];
    end
    rec_new = r;
    now_cls = c;
  end

  always_comb begin
    valid_next = valid_q;
    cls_next   = cls_q;
    if (state_q == StWrite) begin
      valid_next[sel_q] = 1'b1;
      cls_next[sel_q]   = now_cls;
    end
  end

  // chosen slot is read while sel_q is final, data arrives in StWrite
  assign ram_we    = (state_q == StWrite);
  assign ram_waddr = sel_q;
  assign ram_wdata = rec_new;
  assign ram_raddr = (state_q == StRdSlot) ? sel_q : idx_q;

  // ---------------- sequencer ----------------
  assign dv_start = (state_q == StDecay) && score_q != 16'd0 &&
                    item_q.now_time >= last_decay_q && cfg_q.decay_interval != 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      valid_q      <= '0;
      cls_q        <= '0;
      score_q      <= '0;
      last_decay_q <= '0;
      total_q      <= '0;
      res_v_q      <= 1'b0;
      out_v_q      <= 1'b0;
      idx_q        <= '0;
    end else begin
      // output register
      if (out_free) begin
        out_v_q <= res_v_q;
        if (res_v_q) begin
          out_q   <= res_q;
          res_v_q <= 1'b0;
        end
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            item_q <= in_item_i;
            if (!in_item_i.command && (weak_in || in_item_i.muted)) begin
              res_q <= '{outcome: weak_in ? stds_pkg::OutWeak : stds_pkg::OutMuted,
                         score: score_q,
                         level: level_of(score_q),
                         classified_count: 7'(cls_cnt),
                         sighting_count: total_q,
                         default: '0};
              res_v_q <= 1'b1;
            end else begin
              state_q <= StDecay;
            end
          end
        end
        StDecay: begin
          idx_q      <= '0;
          hit_q      <= 1'b0;
          vic_unc_q  <= 1'b0;
          free_q     <= 1'b0;
          if (dv_start) begin
            state_q <= StDecayWait;
          end else begin
            if (score_q != 16'd0 && item_q.now_time >= last_decay_q) begin
              score_q <= '0;      // zero interval decays fully
            end
            if (score_q == 16'd0 || (item_q.now_time >= last_decay_q)) begin
              last_decay_q <= item_q.now_time;
            end
            state_q <= StScanRd;
          end
        end
        StDecayWait: begin
          if (dv_done) begin
            state_q <= StTick;    // reuse as settle step of quotient
          end
        end
        StTick: begin
          if (score_q - steps[15:0] == 16'd0) begin
            last_decay_q <= item_q.now_time;
          end else begin
            last_decay_q <= step_time;
          end
          score_q <= score_q - steps[15:0];
          state_q <= StScanRd;
        end
        StScanRd: begin
          state_q <= StScan;      // read of slot idx_q under way
        end
        StScan: begin
          if (item_q.command) begin
            if (valid_q[idx_q] && item_q.now_time >= ram_rdata.last_seen &&
                age > {16'd0, cfg_q.device_ttl}) begin
              valid_q[idx_q] <= 1'b0;
              cls_q[idx_q]   <= 1'b0;
            end
          end else if (!valid_q[idx_q]) begin
            if (!free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= idx_q;
            end
          end else begin
            if (!hit_q && ram_rdata.address == item_q.mac_address) begin
              hit_q <= 1'b1;
              sel_q <= idx_q;
            end
            if (!cls_q[idx_q] && (!vic_unc_q || ram_rdata.last_seen < vic_seen_q)) begin
              vic_unc_q  <= 1'b1;
              vic_q      <= idx_q;
              vic_seen_q <= ram_rdata.last_seen;
            end
            if (idx_q == '0 || ram_rdata.last_seen < old_seen_q) begin
              old_q      <= idx_q;
              old_seen_q <= ram_rdata.last_seen;
            end
          end
          if (is_last) begin
            state_q <= item_q.command ? StEmit : StApply;
          end else begin
            idx_q   <= idx_q + SlotW'(1);
            state_q <= StScanRd;
          end
        end
        StApply: begin
          if (!hit_q) begin
            sel_q <= free_q ? free_idx_q : (vic_unc_q ? vic_q : old_q);
          end
          state_q <= StRdSlot;
        end
        StRdSlot: begin
          state_q <= StWrite;     // read of chosen slot under way
        end
        StWrite: begin
          valid_q <= valid_next;
          cls_q   <= cls_next;
          score_q <= score_new;
          total_q <= total_q + 32'd1;
          res_q <= '{outcome: now_cls ? stds_pkg::OutReportable : stds_pkg::OutTracked,
                     slot_index: 6'(sel_q),
                     device_class: (now_cls && !rec_new.follower) ? rec_new.class_code
                                                                 : 4'd0,
                     is_follower: now_cls && rec_new.follower,
                     hit_count: rec_new.hits,
                     best_rssi: rec_new.rssi,
                     score: score_new,
                     level: level_of(score_new),
                     classified_count: 7'(cls_cnt),
                     sighting_count: total_q + 32'd1};
          res_v_q <= 1'b1;
          state_q <= StIdle;
        end
        StEmit: begin
          res_q <= '{outcome: stds_pkg::OutTickDone,
                     score: score_q,
                     level: level_of(score_q),
                     classified_count: 7'(cls_cnt),
                     sighting_count: total_q,
                     default: '0};
          res_v_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
